@@ hdl/fglz_pkg.sv @@
// fglz_pkg: shared types and constants of the flag-group lz decompressor
// no dependencies
`timescale 1ns / 1ps
package fglz_pkg;
   localparam int WindowBytesDefault = 4096;
   localparam int HeaderBytesDefault = 16;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
   localparam logic [2:0] ST_OVER_LIM  = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;
   localparam logic [2:0] ST_BEFORE    = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   localparam logic [0:0] REG_MAX_OUTPUT_SIZE = 1'd0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte_0;
      logic [7:0] out_byte_1;
      logic [7:0] out_byte_2;
      logic [7:0] out_byte_3;
      logic [7:0] out_byte_4;
      logic [7:0] out_byte_5;
      logic [7:0] out_byte_6;
      logic [7:0] out_byte_7;
      logic [3:0] byte_count;
      logic       run_last;
      logic       stream_done;
      logic [2:0] status;
   } rsp_type;

   // command from the parser to the copy engine
   typedef struct packed {
      logic        is_copy;    // else literal or status-only
      logic [7:0]  lit;
      logic [11:0] dist_m1;
      logic [8:0]  len;
      logic        emit_lit;
      logic [2:0]  status;     // nonzero: status result
      logic        trunc;      // append truncated status
      logic        last;       // restart stream afterwards
      logic        has_rsp;    // produces at least one result
   } cmd_type;
endpackage

@@ hdl/fglz_front.sv @@
// fglz_front: header check and token parsing, issues commands to the back end
// depends on fglz_pkg
`timescale 1ns / 1ps
module fglz_front import fglz_pkg::*; #(
   parameter int HEADER_BYTES = HeaderBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   input  logic [31:0] max_size,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd,
   output logic [31:0] decl_size
);
   localparam int HW = $clog2(HEADER_BYTES + 1);

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001, PH_FLAG = 6'b000010, PH_TOKEN = 6'b000100,
      PH_REF2 = 6'b001000, PH_REF3 = 6'b010000, PH_HALT = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [HW-1:0] hpos_ff, hpos_in;
   logic        magic_bad_ff, magic_bad_in;
   logic [31:0] decl_ff, decl_in;
   logic [32:0] wr_ff, wr_in;   // bytes issued, tracked here to classify
   logic [7:0]  flags_ff, flags_in;
   logic [3:0]  left_ff, left_in;
   logic [7:0]  ref_a_ff, ref_a_in, ref_b_ff, ref_b_in;
   logic        fin_ff, fin_in;
   cmd_type     c;
   logic [7:0]  b;
   logic [7:0]  magic_ch;
   logic [8:0]  clen;
   logic        do_copy;
   logic [12:0] ref_dist;
   logic [33:0] wr_end;

   assign req_full = !cmd_ready;
   assign b = req_data.in_byte;
   assign decl_size = decl_ff;

   always_comb begin
      unique case (hpos_ff[1:0])
         2'd0: magic_ch = 8'h59;
         2'd1: magic_ch = 8'h61;
         2'd2: magic_ch = 8'h7A;
         default: magic_ch = 8'h30;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; hpos_in = hpos_ff; magic_bad_in = magic_bad_ff;
      decl_in = decl_ff; wr_in = wr_ff; flags_in = flags_ff; left_in = left_ff;
      ref_a_in = ref_a_ff; ref_b_in = ref_b_ff; fin_in = fin_ff;
      c = '0;
      do_copy = 1'b0; clen = '0;
      ref_dist = {1'b0, ref_a_ff[3:0], ref_b_ff} + 13'd1;
      wr_end = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hpos_ff < HW'(4)) begin
               if (b != magic_ch) magic_bad_in = 1'b1;
            end else if (hpos_ff < HW'(8)) begin
               decl_in = {decl_ff[23:0], b};
            end
            hpos_in = hpos_ff + HW'(1);
            if (hpos_in >= HW'(HEADER_BYTES)) begin
               if (magic_bad_in) c.status = ST_BAD_MAGIC;
               else if (decl_in == '0) c.status = ST_ZERO_SIZE;
               else if (decl_in > max_size) c.status = ST_OVER_LIM;
               else phase_in = PH_FLAG;
               if (c.status != ST_OK) begin
                  fin_in = 1'b1; phase_in = PH_HALT;
               end
            end
         end
         PH_FLAG: begin
            flags_in = b; left_in = 4'd8; phase_in = PH_TOKEN;
         end
         PH_TOKEN: begin
            if (flags_ff[7]) begin
               if (wr_ff >= {1'b0, max_size}) begin
                  c.status = ST_OVERFLOW; fin_in = 1'b1; phase_in = PH_HALT;
               end else begin
                  c.emit_lit = 1'b1; c.lit = b;
                  wr_in = wr_ff + 33'd1;
               end
            end else begin
               ref_a_in = b; phase_in = PH_REF2;
            end
         end
         PH_REF2: begin
            ref_b_in = b;
            if (ref_a_ff[7:4] != 4'd0) begin
               do_copy = 1'b1; clen = {5'd0, ref_a_ff[7:4]} + 9'd2;
            end else phase_in = PH_REF3;
         end
         PH_REF3: begin
            do_copy = 1'b1; clen = {1'b0, b} + 9'd18;
         end
         default: ;
      endcase
      if (do_copy) begin
         ref_dist = {1'b0, ref_a_ff[3:0], ref_b_in} + 13'd1;
         wr_end = {1'b0, wr_ff} + {25'd0, clen};
         if ({20'd0, ref_dist} > wr_ff) begin
            c.status = ST_BEFORE; fin_in = 1'b1; phase_in = PH_HALT;
         end else if (wr_end > {2'b0, max_size}) begin
            c.status = ST_OVERFLOW; fin_in = 1'b1; phase_in = PH_HALT;
         end else begin
            c.is_copy = 1'b1; c.len = clen;
            c.dist_m1 = {ref_a_ff[3:0], ref_b_in};
            wr_in = wr_end[32:0];
         end
      end
      if (c.emit_lit || c.is_copy) begin
         flags_in = {flags_ff[6:0], 1'b0};
         left_in = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
         phase_in = (left_in != 4'd0) ? PH_TOKEN : PH_FLAG;
         if (wr_in >= {1'b0, decl_ff}) begin
            fin_in = 1'b1; phase_in = PH_HALT;
         end
      end
      c.last = req_data.in_last;
      c.trunc = req_data.in_last && !fin_in;
      c.has_rsp = c.emit_lit || c.is_copy || (c.status != ST_OK) || c.trunc;
      if (req_data.in_last) begin
         phase_in = PH_HEADER; hpos_in = '0; magic_bad_in = 1'b0; decl_in = '0;
         wr_in = '0; flags_in = '0; left_in = '0; ref_a_in = '0; ref_b_in = '0;
         fin_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; hpos_ff <= '0; magic_bad_ff <= 1'b0;
         decl_ff <= '0; wr_ff <= '0; flags_ff <= '0; left_ff <= '0;
         ref_a_ff <= '0; ref_b_ff <= '0; fin_ff <= 1'b0;
      end else if (req_push && cmd_ready) begin
         phase_ff <= phase_in; hpos_ff <= hpos_in; magic_bad_ff <= magic_bad_in;
         decl_ff <= decl_in; wr_ff <= wr_in; flags_ff <= flags_in;
         left_ff <= left_in; ref_a_ff <= ref_a_in; ref_b_ff <= ref_b_in;
         fin_ff <= fin_in;
      end
   end

   // a closing request always goes down so the back end restarts its count
   assign cmd_valid = req_push && cmd_ready && (c.has_rsp || c.last);
   always_comb begin
      cmd = c;
      cmd.lit = c.lit;
      // stream_done per result is decided in the back end against the size
   end
endmodule

@@ hdl/fglz_queue.sv @@
// fglz_queue: small command queue between parser and copy engine
// depends on fglz_pkg
`timescale 1ns / 1ps
module fglz_queue import fglz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_data,
   input  logic [31:0] wr_decl,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_data,
   output logic [31:0] rd_decl
);
   cmd_type     mem_ff [2];
   logic [31:0] decl_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign rd_decl = decl_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) begin
         mem_ff[wp_ff] <= wr_data;
         decl_ff[wp_ff] <= wr_decl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= !wp_ff;
         if (rd_valid && rd_ready) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
      end
   end
endmodule

@@ hdl/fglz_back.sv @@
// fglz_back: copy engine with history window and result register
// depends on fglz_pkg
`timescale 1ns / 1ps
module fglz_back import fglz_pkg::*; #(
   parameter int WINDOW_BYTES = WindowBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   input  logic [31:0] decl,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);
   localparam int AW = $clog2(WINDOW_BYTES);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_RD = 4'b0010, S_WR = 4'b0100, S_TAIL = 4'b1000
   } st_type;

   logic [7:0]  win [WINDOW_BYTES];
   st_type      st_ff;
   cmd_type     cur_ff;
   logic [31:0] decl_ff;
   logic [31:0] wr_ff;        // bytes written this stream
   logic [8:0]  rem_ff;
   logic [7:0]  grp_ff [8];
   logic [3:0]  gcnt_ff;
   logic [7:0]  rd_q;
   logic [AW-1:0] rd_addr;
   logic        out_full_ff;
   rsp_type     out_ff;
   logic        out_free;
   logic        grp_flush;
   logic        out_load;

   assign out_free = !out_full_ff || rsp_pop;
   assign rsp_empty = !out_full_ff;
   assign rsp_data = out_ff;
   assign cmd_ready = (st_ff == S_IDLE) && out_free;
   assign rd_addr = AW'(wr_ff - {20'd0, cur_ff.dist_m1} - 32'd1);

   always_ff @(posedge clock) rd_q <= win[rd_addr];

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && cmd_valid && cmd_ready && cmd.emit_lit)
         win[AW'(wr_ff)] <= cmd.lit;
      else if (st_ff == S_WR)
         win[AW'(wr_ff)] <= rd_q;
   end

   assign grp_flush = (st_ff == S_WR) && (gcnt_ff == 4'd7 || rem_ff == 9'd1);

   // result register loads
   assign out_load = (st_ff == S_IDLE && cmd_valid && cmd_ready && cmd.has_rsp &&
                      !cmd.is_copy) ||
                     (grp_flush && out_free) ||
                     (st_ff == S_TAIL && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; wr_ff <= '0; out_full_ff <= 1'b0; gcnt_ff <= '0;
      end else begin
         out_full_ff <= out_load || (out_full_ff && !rsp_pop);
         unique case (st_ff)
            S_IDLE: if (cmd_valid && cmd_ready) begin
               cur_ff <= cmd; decl_ff <= decl;
               if (cmd.emit_lit) begin
                  out_ff <= '{out_byte_0: cmd.lit, byte_count: 4'd1,
                              run_last: !cmd.trunc,
                              stream_done: (wr_ff + 32'd1) >= decl, default: '0};
                  wr_ff <= (cmd.last && !cmd.trunc) ? '0 : wr_ff + 32'd1;
                  st_ff <= cmd.trunc ? S_TAIL : S_IDLE;
               end else if (cmd.is_copy) begin
                  rem_ff <= cmd.len; gcnt_ff <= '0; st_ff <= S_RD;
               end else begin
                  if (cmd.has_rsp)
                     out_ff <= '{status: (cmd.status != ST_OK) ? cmd.status : ST_TRUNC,
                                 run_last: 1'b1, default: '0};
                  if (cmd.last) wr_ff <= '0;
               end
            end
            S_RD: st_ff <= S_WR;
            S_WR: if (!grp_flush || out_free) begin
               grp_ff[gcnt_ff[2:0]] <= rd_q;
               wr_ff <= (rem_ff == 9'd1 && cur_ff.last && !cur_ff.trunc) ? '0 :
                        wr_ff + 32'd1;
               rem_ff <= rem_ff - 9'd1;
               gcnt_ff <= grp_flush ? 4'd0 : gcnt_ff + 4'd1;
               if (grp_flush) begin
                  out_ff <= '{out_byte_0: (gcnt_ff == 4'd0) ? rd_q : grp_ff[0],
                     out_byte_1: (gcnt_ff > 4'd1) ? grp_ff[1] : (gcnt_ff == 4'd1 ? rd_q : 8'd0),
                     out_byte_2: (gcnt_ff > 4'd2) ? grp_ff[2] : (gcnt_ff == 4'd2 ? rd_q : 8'd0),
                     out_byte_3: (gcnt_ff > 4'd3) ? grp_ff[3] : (gcnt_ff == 4'd3 ? rd_q : 8'd0),
                     out_byte_4: (gcnt_ff > 4'd4) ? grp_ff[4] : (gcnt_ff == 4'd4 ? rd_q : 8'd0),
                     out_byte_5: (gcnt_ff > 4'd5) ? grp_ff[5] : (gcnt_ff == 4'd5 ? rd_q : 8'd0),
                     out_byte_6: (gcnt_ff > 4'd6) ? grp_ff[6] : (gcnt_ff == 4'd6 ? rd_q : 8'd0),
                     out_byte_7: (gcnt_ff == 4'd7) ? rd_q : 8'd0,
                     byte_count: gcnt_ff + 4'd1,
                     run_last: (rem_ff == 9'd1) && !cur_ff.trunc,
                     stream_done: (wr_ff + 32'd1) >= decl_ff, status: ST_OK};
               end
               if (rem_ff == 9'd1) begin
                  st_ff <= cur_ff.trunc ? S_TAIL : S_IDLE;
               end else st_ff <= S_RD;
            end
            S_TAIL: if (out_free) begin
               out_ff <= '{status: ST_TRUNC, run_last: 1'b1, default: '0};
               wr_ff <= '0;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> out_ff.byte_count <= 4'd8) else $error("bad byte count");
   a_status_no_bytes: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && out_ff.status != ST_OK |-> out_ff.byte_count == 4'd0)
      else $error("status carries bytes");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(out_ff))
      else $error("result lost");
`endif
endmodule

@@ hdl/flag_group_lz_decompressor.sv @@
// flag_group_lz_decompressor: top level, csr port, parser, queue and copy engine
// depends on fglz_pkg, fglz_front, fglz_queue, fglz_back
`timescale 1ns / 1ps
// Yaz0-style decompressor taking one compressed byte per request and giving
// results in groups of up to eight bytes. the parser takes one request per
// cycle while the command queue has room; a literal is handled in the copy
// engine's idle state. a back-reference of length n holds the copy engine for
// the step that takes the command, then a window read state and a window
// write state per byte through a one-read, one-write history memory.
// a truncated stream adds a tail state for its status result, and the engine
// waits whenever a result is due while the result register is still full. the
// parser runs ahead through a two-entry command queue. no reset clearing of the
// window is done: reads of unwritten entries never occur.
module flag_group_lz_decompressor import fglz_pkg::*; #(
   parameter int WINDOW_BYTES = WindowBytesDefault,
   parameter int HEADER_BYTES = HeaderBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] max_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   cmd_type     f_cmd, q_cmd;
   logic [31:0] q_decl, f_decl;

   // csr: one register at address 0
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MAX_OUTPUT_SIZE) ? max_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) max_ff <= 32'hFFFF_FFFF;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MAX_OUTPUT_SIZE)
         max_ff <= csr_pwdata;
   end

   fglz_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data, .max_size(max_ff),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd), .decl_size(f_decl));

   // declared size travels with each command
   fglz_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .wr_decl(f_decl), .rd_valid(q_valid), .rd_ready(q_ready),
      .rd_data(q_cmd), .rd_decl(q_decl));

   fglz_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .decl(q_decl), .rsp_empty, .rsp_pop, .rsp_data);
endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for flag_group_lz_decompressor
// depends on fglz_pkg and the flag_group_lz_decompressor rtl
`timescale 1ns / 1ps
module testbench;
   import fglz_pkg::*;

   localparam int WIN = 4096;
   localparam int HDR = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 700;          // covers the longest copy of 273 bytes
   localparam logic [3:0] NO_WANT = 4'hF;

   typedef enum logic [2:0] {
      PH_HEADER, PH_FLAG, PH_TOKEN, PH_REF2, PH_REF3, PH_HALT
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
      logic [3:0] want_status;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   flag_group_lz_decompressor dut (.*);

   always #5 clock = ~clock;

   // cycle counter and timeout
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // decoder model state, its own copy of the limit register
   logic [7:0]  win [WIN];
   logic [31:0] written, declared, out_limit;
   int          hdr_pos;
   logic [7:0]  flags;
   int          flags_left;
   phase_type   phase;
   logic [7:0]  ref_a, ref_b;
   bit          finished, magic_bad;

   rsp_type     expected_groups[$];
   rsp_type     step_groups[$];
   int          errors = 0;
   int          checked = 0;
   int          streams = 0;
   int          requests = 0;
   bit          quiet = 0;      // no idling in the tail
   bit          hold_req = 0;   // long receiver hold-off

   function automatic void clear_stream();
      written = 0; declared = 0; hdr_pos = 0; flags = 0; flags_left = 0;
      phase = PH_HEADER; ref_a = 0; ref_b = 0; finished = 0; magic_bad = 0;
   endfunction

   function automatic void add_group(logic [7:0] b[8], int cnt, bit done,
                                     logic [2:0] st);
      rsp_type r;
      r = '0;
      r.out_byte_0 = cnt > 0 ? b[0] : 8'h0;
      r.out_byte_1 = cnt > 1 ? b[1] : 8'h0;
      r.out_byte_2 = cnt > 2 ? b[2] : 8'h0;
      r.out_byte_3 = cnt > 3 ? b[3] : 8'h0;
      r.out_byte_4 = cnt > 4 ? b[4] : 8'h0;
      r.out_byte_5 = cnt > 5 ? b[5] : 8'h0;
      r.out_byte_6 = cnt > 6 ? b[6] : 8'h0;
      r.out_byte_7 = cnt > 7 ? b[7] : 8'h0;
      r.byte_count = cnt[3:0];
      r.stream_done = done;
      r.status = st;
      step_groups.push_back(r);
   endfunction

   function automatic void halt_with(logic [2:0] st);
      logic [7:0] none[8];
      none = '{default: 8'h0};
      add_group(none, 0, 0, st);
      finished = 1;
      phase = PH_HALT;
   endfunction

   function automatic void close_token();
      flags = flags << 1;
      if (flags_left > 0) flags_left--;
      phase = flags_left != 0 ? PH_TOKEN : PH_FLAG;
      if (written >= declared) begin
         finished = 1;
         phase = PH_HALT;
      end
   endfunction

   function automatic void run_copy(int len);
      logic [31:0] ref_dist;
      logic [7:0]  grp[8];
      logic [7:0]  v;
      int          cnt;
      ref_dist = {20'h0, ref_a[3:0], ref_b} + 1;
      cnt = 0;
      grp = '{default: 8'h0};
      if (ref_dist > written) begin
         halt_with(ST_BEFORE);
         return;
      end
      if ({32'h0, written} + len > {32'h0, out_limit}) begin
         halt_with(ST_OVERFLOW);
         return;
      end
      for (int i = 0; i < len; i++) begin
         v = win[(written - ref_dist) % WIN];
         win[written % WIN] = v;
         written++;
         grp[cnt] = v;
         cnt++;
         if (cnt == 8 || i + 1 == len) begin
            add_group(grp, cnt, written >= declared, ST_OK);
            cnt = 0;
         end
      end
      close_token();
   endfunction

   // works out the result groups caused by one accepted request
   function automatic void decode_byte(req_type r);
      logic [7:0] b;
      logic [7:0] one[8];
      logic [7:0] magic[4];
      b = r.in_byte;
      one = '{default: 8'h0};
      magic = '{8'h59, 8'h61, 8'h7A, 8'h30};
      step_groups.delete();
      case (phase)
         PH_HEADER: begin
            if (hdr_pos < 4) begin
               if (b != magic[hdr_pos]) magic_bad = 1;
            end else if (hdr_pos < 8) begin
               declared = {declared[23:0], b};
            end
            hdr_pos++;
            if (hdr_pos >= HDR) begin
               if (magic_bad) halt_with(ST_BAD_MAGIC);
               else if (declared == 0) halt_with(ST_ZERO_SIZE);
               else if (declared > out_limit) halt_with(ST_OVER_LIM);
               else phase = PH_FLAG;
            end
         end
         PH_FLAG: begin
            flags = b;
            flags_left = 8;
            phase = PH_TOKEN;
         end
         PH_TOKEN: begin
            if (flags[7]) begin
               if (written >= out_limit) begin
                  halt_with(ST_OVERFLOW);
               end else begin
                  win[written % WIN] = b;
                  written++;
                  one[0] = b;
                  add_group(one, 1, written >= declared, ST_OK);
                  close_token();
               end
            end else begin
               ref_a = b;
               phase = PH_REF2;
            end
         end
         PH_REF2: begin
            ref_b = b;
            if (ref_a[7:4] != 0) run_copy(ref_a[7:4] + 2);
            else phase = PH_REF3;
         end
         PH_REF3: run_copy(b + 18);
         default: ;
      endcase
      if (r.in_last) begin
         // stream cut short appends a truncation status
         if (!finished) halt_with(ST_TRUNC);
         clear_stream();
      end
      if (step_groups.size() > 0) step_groups[$].run_last = 1;
      foreach (step_groups[i]) expected_groups.push_back(step_groups[i]);
   endfunction

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   task automatic send_byte(req_type r);
      bit stalled;
      req_push <= 1;
      req_data <= r;
      do begin
         @(negedge clock);
         stalled = req_full;
         @(posedge clock);
      end while (stalled);
      decode_byte(r);
      requests++;
      // random gaps between requests
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 0;
      wait (expected_groups.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= REG_MAX_OUTPUT_SIZE; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      out_limit = v;
      // read back through the same port
      csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
      csr_penable <= 1;
      @(negedge clock);
      if (csr_prdata !== v) begin
         $display("%0t limit readback: expected %h, actual %h", $time, v, csr_prdata);
         errors++;
      end
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0;
   endtask

   // builds one compressed stream, mostly well formed
   task automatic make_stream(ref req_type s[$]);
      logic [7:0]  hdr[HDR];
      logic [31:0] size;
      int mode, produced, d, len, cut;
      logic [7:0] f;
      bit is_long;
      s.delete();
      mode = $urandom_range(0, 19);
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
      if (mode == 1) size = 0;
      if (mode == 2 && out_limit != 32'hFFFFFFFF) size = out_limit + 1;
      hdr = '{0: 8'h59, 1: 8'h61, 2: 8'h7A, 3: 8'h30, 4: size[31:24], 5: size[23:16],
              6: size[15:8], 7: size[7:0], default: 8'h0};
      for (int i = 8; i < HDR; i++) hdr[i] = $urandom_range(0, 255);
      if (mode == 0) hdr[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      foreach (hdr[i]) s.push_back('{hdr[i], 1'b0});
      produced = 0;
      while (mode > 2 && produced < size) begin
         f = $urandom_range(0, 255);
         if (produced == 0 && $urandom_range(0, 3) != 0) f[7] = 1;
         s.push_back('{f, 1'b0});
         for (int k = 7; k >= 0 && produced < size; k--) begin
            if (f[k]) begin
               s.push_back('{8'($urandom_range(0, 255)), 1'b0});
               produced++;
            end else begin
               if (produced > 0 && $urandom_range(0, 9) != 0)
                  d = $urandom_range(1, produced < WIN ? produced : WIN);
               else
                  d = $urandom_range(1, WIN);
               is_long = $urandom_range(0, 9) == 0;
               len = is_long ? $urandom_range(18, 273) : $urandom_range(3, 17);
               s.push_back('{is_long ? {4'h0, 4'((d - 1) >> 8)}
                                     : {4'(len - 2), 4'((d - 1) >> 8)}, 1'b0});
               s.push_back('{8'(d - 1), 1'b0});
               if (is_long) s.push_back('{8'(len - 18), 1'b0});
               produced += len;
            end
         end
      end
      // trailing bytes past the end are ignored by the block
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 5)) s.push_back('{8'($urandom_range(0, 255)), 1'b0});
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, s.size());
         while (s.size() > cut) void'(s.pop_back());
      end
      s[$].in_last = 1;
   endtask

   // directed stream: largest declared size, then a back-reference far before
   // the start, then a closing byte that is ignored
   row_type directed[] = '{
      '{8'h59, 0, NO_WANT}, '{8'h61, 0, NO_WANT}, '{8'h7A, 0, NO_WANT},
      '{8'h30, 0, NO_WANT}, '{8'hFF, 0, NO_WANT}, '{8'hFF, 0, NO_WANT},
      '{8'hFF, 0, NO_WANT}, '{8'hFF, 0, NO_WANT}, '{8'h00, 0, NO_WANT},
      '{8'hFF, 0, NO_WANT}, '{8'h00, 0, NO_WANT}, '{8'hFF, 0, NO_WANT},
      '{8'h00, 0, NO_WANT}, '{8'hFF, 0, NO_WANT}, '{8'h00, 0, NO_WANT},
      '{8'hFF, 0, NO_WANT},
      '{8'h7F, 0, NO_WANT},                  // flags: reference first
      '{8'h0F, 0, NO_WANT},                  // long form, distance high bits
      '{8'hFF, 0, NO_WANT},                  // distance 4096
      '{8'h00, 0, {1'b0, ST_BEFORE}},        // length byte, nothing written yet
      '{8'hAA, 1, NO_WANT}                   // ignored, already ended
   };

   int limits[4] = '{32'hFFFFFFFF, 0, 64, 32'hFFFFFFFF};
   int budget[4] = '{80, 30, 70, 80};

   initial begin
      req_type s[$];
      int start;
      clear_stream();
      out_limit = 32'hFFFFFFFF;
      for (int i = 0; i < WIN; i++) win[i] = 8'h0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_byte('{directed[i].in_byte, directed[i].in_last});
         if (directed[i].want_status != NO_WANT &&
             expected_groups[$].status !== directed[i].want_status[2:0]) begin
            $display("%0t directed row %0d: expected status %0d, actual %0d", $time,
                     i, directed[i].want_status, expected_groups[$].status);
            errors++;
         end
      end
      streams++;
      drain();

      // phases with different limits, written only while idle
      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         if (p == 3) hold_req = 1;
         start = requests;
         while (requests - start < budget[p]) begin
            if (p == 3 && requests - start > budget[p] / 2) quiet = 1;
            make_stream(s);
            foreach (s[i]) send_byte(s[i]);
            streams++;
         end
         drain();
      end

      $display("%0d streams, %0d requests, %0d result groups checked", streams,
               requests, checked);
      $display("limits covered: unlimited, zero and 64 bytes");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // receiver side
   // ---------------------------------------------------------------
   task automatic check_field(string name, int e, int a);
      if (e != a) begin
         $display("%0t %s: expected %0d, actual %0d", $time, name, e, a);
         errors++;
      end
   endtask

   initial begin
      bit      was_empty, was_pop;
      rsp_type got, want;
      int      stall;
      bit      held;
      stall = 0;
      held = 0;
      forever begin
         @(negedge clock);
         was_empty = rsp_empty;
         was_pop = rsp_pop;
         got = rsp_data;
         @(posedge clock);
         if (reset) continue;
         if (was_pop && !was_empty) begin
            if (expected_groups.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_groups.pop_front();
               checked++;
               check_field("out_byte_0", want.out_byte_0, got.out_byte_0);
               check_field("out_byte_1", want.out_byte_1, got.out_byte_1);
               check_field("out_byte_2", want.out_byte_2, got.out_byte_2);
               check_field("out_byte_3", want.out_byte_3, got.out_byte_3);
               check_field("out_byte_4", want.out_byte_4, got.out_byte_4);
               check_field("out_byte_5", want.out_byte_5, got.out_byte_5);
               check_field("out_byte_6", want.out_byte_6, got.out_byte_6);
               check_field("out_byte_7", want.out_byte_7, got.out_byte_7);
               check_field("byte_count", want.byte_count, got.byte_count);
               check_field("run_last", want.run_last, got.run_last);
               check_field("stream_done", want.stream_done, got.stream_done);
               check_field("status", want.status, got.status);
            end
         end
         // one long hold-off so the block fills and pushes back
         if (hold_req && !held) begin
            held = 1;
            stall = 400;
         end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 11);
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= 1;
         end
      end
   end
endmodule
